// ===== design/maze_wall_union_find_macros.svh =====
// Assertion macros for the maze wall union-find block.
// Used by the controller and datapath; no other dependencies.
`ifndef MAZE_WALL_UNION_FIND_MACROS_SVH
`define MAZE_WALL_UNION_FIND_MACROS_SVH
`ifndef SYNTHESIS
`define MWUF_ASSERT_IMP(lbl, clk, rst, a, b) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error("lbl");
`define MWUF_ASSERT_NEXT(lbl, clk, rst, a, b) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error("lbl");
`else
`define MWUF_ASSERT_IMP(lbl, clk, rst, a, b)
`define MWUF_ASSERT_NEXT(lbl, clk, rst, a, b)
`endif
`endif

// ===== design/mwuf_pkg.sv =====
// Shared types and constants for the maze wall union-find block.
// No dependencies.
package mwuf_pkg;
   localparam int MaxRows = 16;
   localparam int MaxCols = 16;
   localparam int Cells = MaxRows * MaxCols;
   localparam int CellW = $clog2(Cells);
   localparam int RowW = $clog2(MaxRows);
   localparam int ColW = $clog2(MaxCols);

   localparam logic [1:0] DirNorth = 2'd0;
   localparam logic [1:0] DirSouth = 2'd1;
   localparam logic [1:0] DirEast = 2'd2;
   localparam logic [1:0] DirWest = 2'd3;
   localparam logic OpTry = 1'b0;
   localparam logic OpRead = 1'b1;

   // datapath commands
   typedef enum logic [3:0] {
      CMD_NONE   = 4'd0,
      CMD_CLEAR  = 4'd1,   // one cell of the post-reset clearing pass
      CMD_LOAD   = 4'd2,   // latch item, compute bounds and neighbour
      CMD_RDWALL = 4'd3,   // set current cell from sel, to read its walls
      CMD_OPEN0  = 4'd4,   // clear north wall of cell 0
      CMD_OPEN1  = 4'd5,   // clear south wall of exit cell
      CMD_FSTART = 4'd6,   // start a find; sel picks the start cell
      CMD_FSTEP  = 4'd7,   // parent read result checked, walk on
      CMD_FSAVE  = 4'd8,   // store found root into slot sel
      CMD_KNOCK0 = 4'd9,   // clear wall of here, set parent
      CMD_KNOCK1 = 4'd10,  // clear wall of neighbour
      CMD_RESULT = 4'd11
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type op;
      logic [1:0] sel;     // find start: 0 here,1 other,2 cell0,3 exit
      logic       knocked;
      logic       set_done;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic oor;
      logic is_read;
      logic nb_ok;
      logic find_done;
      logic roots_eq;      // slot0 == slot1
   } stat_type;
endpackage

// ===== design/mwuf_datapath.sv =====
// Datapath: wall and parent memories, find walker, config registers.
// Depends on mwuf_pkg and the assertion macros header.
`include "maze_wall_union_find_macros.svh"
module mwuf_datapath (
   input  logic                        clock,
   input  logic                        reset,
   input  mwuf_pkg::cmd_type           cmd,
   output mwuf_pkg::stat_type          stat,
   input  logic                        req_opcode,
   input  logic [3:0]                  req_row,
   input  logic [3:0]                  req_col,
   input  logic [1:0]                  req_direction,
   input  logic                        cfg_we,
   input  logic                        cfg_idx,
   input  logic [4:0]                  cfg_data,
   output logic [4:0]                  row_count,
   output logic [4:0]                  col_count,
   output logic                        rsp_knocked,
   output logic                        rsp_complete,
   output logic                        rsp_out_of_range,
   output logic [3:0]                  rsp_walls,
   output logic                        rsp_strobe
);
   logic [3:0]                  wall_mem [mwuf_pkg::Cells];
   logic [mwuf_pkg::CellW-1:0]  par_mem  [mwuf_pkg::Cells];

   logic [4:0] rows_ff, cols_ff;
   logic [mwuf_pkg::CellW-1:0] clr_ff;
   logic op_ff, oor_ff, nbok_ff;
   logic [mwuf_pkg::CellW-1:0] here_ff, other_ff, exit_ff, cur_ff;
   logic [3:0] mine_ff, their_ff;
   logic [mwuf_pkg::CellW-1:0] slot_ff [2];
   logic [mwuf_pkg::CellW-1:0] par_rd_ff;
   logic [3:0] wall_rd_ff;
   logic done_ff;
   logic kn_ff, cpl_ff, oorr_ff, strb_ff;
   logic [3:0] walls_ff;

   logic [4:0] er, ec;
   logic [mwuf_pkg::CellW-1:0] here_in, exit_in;
   logic nbok_in;
   logic [mwuf_pkg::CellW-1:0] other_in;
   logic [3:0] mine_in, their_in;

   assign row_count = rows_ff;
   assign col_count = cols_ff;

   always_comb begin
      er = (rows_ff == 5'd0) ? 5'd1 : (rows_ff > 5'(mwuf_pkg::MaxRows)) ?
           5'(mwuf_pkg::MaxRows) : rows_ff;
      ec = (cols_ff == 5'd0) ? 5'd1 : (cols_ff > 5'(mwuf_pkg::MaxCols)) ?
           5'(mwuf_pkg::MaxCols) : cols_ff;
      here_in = {req_row, req_col};
      exit_in = {4'(er - 5'd1), 4'(ec - 5'd1)};
      nbok_in = 1'b0;
      other_in = here_in;
      mine_in = 4'd0;
      their_in = 4'd0;
      unique case (req_direction)
         mwuf_pkg::DirNorth: begin
            nbok_in = req_row != 4'd0; other_in = {4'(req_row - 4'd1), req_col};
            mine_in = 4'b0001; their_in = 4'b0010;
         end
         mwuf_pkg::DirSouth: begin
            nbok_in = ({1'b0, req_row} + 5'd1) < er;
            other_in = {4'(req_row + 4'd1), req_col};
            mine_in = 4'b0010; their_in = 4'b0001;
         end
         mwuf_pkg::DirEast: begin
            nbok_in = ({1'b0, req_col} + 5'd1) < ec;
            other_in = {req_row, 4'(req_col + 4'd1)};
            mine_in = 4'b0100; their_in = 4'b1000;
         end
         default: begin
            nbok_in = req_col != 4'd0; other_in = {req_row, 4'(req_col - 4'd1)};
            mine_in = 4'b1000; their_in = 4'b0100;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= 5'd16; cols_ff <= 5'd16; clr_ff <= '0;
         done_ff <= 1'b0; strb_ff <= 1'b0;
      end else begin
         strb_ff <= cmd.op == mwuf_pkg::CMD_RESULT;
         if (cfg_we) begin
            if (cfg_idx) cols_ff <= cfg_data; else rows_ff <= cfg_data;
         end
         if (cmd.op == mwuf_pkg::CMD_CLEAR)
            clr_ff <= mwuf_pkg::CellW'(clr_ff + 1'b1);
         if (cmd.set_done) done_ff <= 1'b1;
      end
   end

   // memories: one write, one registered read each
   always_ff @(posedge clock) begin
      unique case (cmd.op)
         mwuf_pkg::CMD_CLEAR: begin
            wall_mem[clr_ff] <= 4'hF; par_mem[clr_ff] <= clr_ff;
         end
         mwuf_pkg::CMD_OPEN0:
            wall_mem[mwuf_pkg::CellW'(0)] <= wall_rd_ff & 4'b1110;
         mwuf_pkg::CMD_OPEN1: wall_mem[exit_ff] <= wall_rd_ff & 4'b1101;
         mwuf_pkg::CMD_KNOCK0: begin
            wall_mem[here_ff] <= wall_rd_ff & ~mine_ff;
            par_mem[slot_ff[1]] <= slot_ff[0];
         end
         mwuf_pkg::CMD_KNOCK1: wall_mem[other_ff] <= wall_rd_ff & ~their_ff;
         default: ;
      endcase
      par_rd_ff <= par_mem[cur_ff];
      wall_rd_ff <= wall_mem[cur_ff];
   end

   always_ff @(posedge clock) begin
      unique case (cmd.op)
         mwuf_pkg::CMD_LOAD: begin
            op_ff <= req_opcode;
            oor_ff <= ({1'b0, req_row} >= er) || ({1'b0, req_col} >= ec);
            here_ff <= here_in; other_ff <= other_in; exit_ff <= exit_in;
            nbok_ff <= nbok_in; mine_ff <= mine_in; their_ff <= their_in;
            cur_ff <= here_in;
         end
         mwuf_pkg::CMD_RDWALL, mwuf_pkg::CMD_FSTART: begin
            unique case (cmd.sel)
               2'd0: cur_ff <= here_ff;
               2'd1: cur_ff <= other_ff;
               2'd2: cur_ff <= '0;
               default: cur_ff <= exit_ff;
            endcase
         end
         mwuf_pkg::CMD_FSTEP: if (par_rd_ff != cur_ff) cur_ff <= par_rd_ff;
         mwuf_pkg::CMD_FSAVE: slot_ff[cmd.sel[0]] <= cur_ff;
         mwuf_pkg::CMD_RESULT: begin
            kn_ff <= cmd.knocked; cpl_ff <= done_ff | cmd.set_done;
            oorr_ff <= oor_ff;
            walls_ff <= (op_ff && !oor_ff) ? wall_rd_ff : 4'd0;
         end
         default: ;
      endcase
   end

   always_comb begin
      stat.clear_last = clr_ff == '1;
      stat.oor = oor_ff;
      stat.is_read = op_ff;
      stat.nb_ok = nbok_ff;
      stat.find_done = par_rd_ff == cur_ff;
      stat.roots_eq = slot_ff[0] == slot_ff[1];
   end

   assign rsp_knocked = kn_ff;
   assign rsp_complete = cpl_ff;
   assign rsp_out_of_range = oorr_ff;
   assign rsp_walls = walls_ff;
   assign rsp_strobe = strb_ff;

   `MWUF_ASSERT_NEXT(a_done_sticks, clock, reset, done_ff, done_ff)
   `MWUF_ASSERT_IMP(a_oor_no_walls, clock, reset, strb_ff && oorr_ff, walls_ff == 4'd0 && !kn_ff)
   `MWUF_ASSERT_IMP(a_knock_not_read, clock, reset, strb_ff && kn_ff, walls_ff == 4'd0)
endmodule

// ===== design/mwuf_ctrl.sv =====
// Controller: sequences clearing, item decode, finds and wall updates.
// Depends on mwuf_pkg and the assertion macros header.
`include "maze_wall_union_find_macros.svh"
module mwuf_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  mwuf_pkg::stat_type   stat,
   output mwuf_pkg::cmd_type    cmd
);
   typedef enum logic [19:0] {
      S_CLEAR = 20'h00001,
      S_IDLE  = 20'h00002,
      S_DEC   = 20'h00004,
      S_RDW   = 20'h00008,
      S_RDWW  = 20'h00010,
      S_OP0R  = 20'h00020,
      S_OP0W  = 20'h00040,
      S_OP1R  = 20'h00080,
      S_OP1W  = 20'h00100,
      S_OP1X  = 20'h00200,
      S_FST   = 20'h00400,
      S_FWAIT = 20'h00800,
      S_FCHK  = 20'h01000,
      S_KN    = 20'h02000,
      S_K0W   = 20'h04000,
      S_K0    = 20'h08000,
      S_K1R   = 20'h10000,
      S_K1W   = 20'h20000,
      S_K1    = 20'h40000,
      S_RES   = 20'h80000
   } state_type;

   // find slots: 0 cell0 root, 1 exit root (ends check); then here/other
   state_type state_ff, state_in;
   logic [2:0] phase_ff, phase_in;   // which find of the try
   logic started_ff, started_in, done_ff, done_in, kn_ff, kn_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR; phase_ff <= '0;
         started_ff <= 1'b0; done_ff <= 1'b0; kn_ff <= 1'b0;
      end else begin
         state_ff <= state_in; phase_ff <= phase_in;
         started_ff <= started_in; done_ff <= done_in; kn_ff <= kn_in;
      end
   end

   // phases: 0 find cell0,1 find exit,(check),2 find here,3 find other,
   // (knock),4 find cell0,5 find exit,(check)
   function automatic logic [1:0] fsel(input logic [2:0] ph);
      unique case (ph)
         3'd0, 3'd4: fsel = 2'd2;
         3'd1, 3'd5: fsel = 2'd3;
         3'd2:       fsel = 2'd0;
         default:    fsel = 2'd1;
      endcase
   endfunction

   always_comb begin
      state_in = state_ff; phase_in = phase_ff;
      started_in = started_ff; done_in = done_ff; kn_in = kn_ff;
      cmd = '{op: mwuf_pkg::CMD_NONE, sel: 2'd0, knocked: kn_ff, set_done: 1'b0};
      busy = state_ff != S_IDLE;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.op = mwuf_pkg::CMD_CLEAR;
            if (stat.clear_last) state_in = S_IDLE;
         end
         S_IDLE: if (start) begin
            cmd.op = mwuf_pkg::CMD_LOAD; state_in = S_DEC; kn_in = 1'b0;
         end
         S_DEC: begin
            if (stat.oor) state_in = S_RES;
            else if (stat.is_read) begin
               cmd.op = mwuf_pkg::CMD_RDWALL; cmd.sel = 2'd0; state_in = S_RDW;
            end else if (done_ff) state_in = S_RES;
            else if (!started_ff) begin
               cmd.op = mwuf_pkg::CMD_RDWALL; cmd.sel = 2'd2; state_in = S_OP0R;
            end else begin
               phase_in = 3'd0; state_in = S_FST;
            end
         end
         S_RDW: state_in = S_RDWW;      // read data registered
         S_RDWW: state_in = S_RES;
         S_OP0R: state_in = S_OP0W;
         S_OP0W: begin
            cmd.op = mwuf_pkg::CMD_OPEN0; // entrance: cell 0 north
            state_in = S_OP1R;
         end
         S_OP1R: begin
            cmd.op = mwuf_pkg::CMD_RDWALL; cmd.sel = 2'd3; state_in = S_OP1W;
         end
         S_OP1W: state_in = S_OP1X;
         S_OP1X: begin
            cmd.op = mwuf_pkg::CMD_OPEN1; // exit: last cell south
            started_in = 1'b1; phase_in = 3'd0; state_in = S_FST;
         end
         S_FST: begin
            cmd.op = mwuf_pkg::CMD_FSTART; cmd.sel = fsel(phase_ff); state_in = S_FWAIT;
         end
         S_FWAIT: state_in = S_FCHK;
         S_FCHK: begin
            if (stat.find_done) begin
               cmd.op = mwuf_pkg::CMD_FSAVE; cmd.sel = {1'b0, phase_ff[0]};
               state_in = S_KN;
            end else begin
               cmd.op = mwuf_pkg::CMD_FSTEP; state_in = S_FWAIT;
            end
         end
         S_KN: begin
            // decide after each saved root
            unique case (phase_ff)
               3'd1, 3'd5: begin
                  if (stat.roots_eq) begin
                     cmd.set_done = 1'b1; done_in = 1'b1; state_in = S_RES;
                  end else if (phase_ff == 3'd5 || !stat.nb_ok) state_in = S_RES;
                  else begin
                     phase_in = 3'd2; state_in = S_FST;
                  end
               end
               3'd3: begin
                  if (stat.roots_eq) state_in = S_RES;
                  else begin
                     cmd.op = mwuf_pkg::CMD_RDWALL; cmd.sel = 2'd0; state_in = S_K0W;
                  end
               end
               default: begin phase_in = 3'(phase_ff + 3'd1); state_in = S_FST; end
            endcase
         end
         S_K0W: state_in = S_K0;
         S_K0: begin
            cmd.op = mwuf_pkg::CMD_KNOCK0; kn_in = 1'b1; state_in = S_K1R;
         end
         S_K1R: begin
            cmd.op = mwuf_pkg::CMD_RDWALL; cmd.sel = 2'd1; state_in = S_K1W;
         end
         S_K1W: state_in = S_K1;
         S_K1: begin
            cmd.op = mwuf_pkg::CMD_KNOCK1; phase_in = 3'd4; state_in = S_FST;
         end
         S_RES: begin
            cmd.op = mwuf_pkg::CMD_RESULT; state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   `MWUF_ASSERT_IMP(a_busy_clear, clock, reset, state_ff == S_CLEAR, busy)
   `MWUF_ASSERT_NEXT(a_started_sticks, clock, reset, started_ff, started_ff)
   `MWUF_ASSERT_NEXT(a_res_to_idle, clock, reset, state_ff == S_RES, state_ff == S_IDLE)
endmodule

// ===== design/maze_wall_union_find.sv =====
// Top level of the maze wall union-find block; uses mwuf_pkg, mwuf_ctrl, mwuf_datapath.
// Result word after the accepting edge; out-of-range items and tries once complete skip
// to it, a read waits for a wall read, a try for finds, knocks and first-try openings.
// One word in flight; busy drops as the result shows.
// Reset: sizes go to 16 x 16, then a clearing pass of both memories, busy high.
// The receiver cannot stall: each result word stands for one cycle only.
module maze_wall_union_find (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_opcode,
   input  logic [3:0]  req_row,
   input  logic [3:0]  req_col,
   input  logic [1:0]  req_direction,
   output logic        rsp_valid,
   output logic        rsp_knocked,
   output logic        rsp_complete,
   output logic        rsp_out_of_range,
   output logic        rsp_north_wall,
   output logic        rsp_south_wall,
   output logic        rsp_east_wall,
   output logic        rsp_west_wall,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   mwuf_pkg::cmd_type  cmd;
   mwuf_pkg::stat_type stat;
   logic [4:0] rows, cols;
   logic [3:0] walls;
   logic cfg_we;

   // register write at access phase; rows at 0, columns at 4
   assign pready = 1'b1;
   assign cfg_we = psel && penable && pwrite && (paddr[1:0] == 2'd0);
   assign prdata = {27'd0, paddr[2] ? cols : rows};

   mwuf_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .stat(stat), .cmd(cmd)
   );

   mwuf_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .stat(stat),
      .req_opcode(req_opcode), .req_row(req_row), .req_col(req_col),
      .req_direction(req_direction),
      .cfg_we(cfg_we), .cfg_idx(paddr[2]), .cfg_data(pwdata[4:0]),
      .row_count(rows), .col_count(cols),
      .rsp_knocked(rsp_knocked), .rsp_complete(rsp_complete),
      .rsp_out_of_range(rsp_out_of_range), .rsp_walls(walls),
      .rsp_strobe(rsp_valid)
   );

   assign rsp_north_wall = walls[0];
   assign rsp_south_wall = walls[1];
   assign rsp_east_wall = walls[2];
   assign rsp_west_wall = walls[3];
endmodule
